>>> rtl/bbwt_pkg.sv
// Package for the bitwise BWT encoder: payload widths and the control and
// status structs exchanged between the top level and the rank cells.
// No dependencies.
package bbwt_pkg;

  // Fixed payload widths of the channels
  localparam int DATA_W = 64;
  localparam int PIDX_W = 6;

  // Per-cycle commands broadcast to every rank cell
  typedef struct packed {
    logic load;   // take a new rotation and clear the rank
    logic step;   // compare against the ring value and advance the ring
    logic snap;   // copy rank and last-column bit into the drain stage
    logic shift;  // advance the drain chain by one cell
  } cell_ctrl_t;

  // Comparison of the passing rotation against the cell's own rotation
  typedef struct packed {
    logic lt;     // passing rotation below own rotation
    logic eq;     // passing rotation equals own rotation
  } cell_cmp_t;

endpackage

>>> rtl/bbwt_if.sv
// Valid/ready channel interfaces for the bitwise BWT encoder.
// Depends on bbwt_pkg for payload widths.
interface bbwt_in_if import bbwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);
endinterface

interface bbwt_out_if import bbwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] word_out;
  logic [PIDX_W-1:0] primary_index;

  modport source (output valid, output word_out, output primary_index, input ready);
  modport sink   (input valid, input word_out, input primary_index, output ready);
endinterface

>>> rtl/bbwt_cell.sv
// Rank cell of the bitwise BWT encoder: holds one rotation, counts how many
// rotations rank ahead of it as the ring passes by, then drains its rank.
// Depends on bbwt_pkg.
module bbwt_cell import bbwt_pkg::*; #(
  parameter int WORD_BITS = 64,
  parameter int CELL_IDX  = 0
) (
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic [WORD_BITS-1:0]         load_word,
  input  logic [WORD_BITS-1:0]         ring_word_in,
  input  logic [$clog2(WORD_BITS)-1:0] ring_tag_in,
  input  logic [$clog2(WORD_BITS)-1:0] drain_rank_in,
  input  logic                         drain_lsb_in,
  output logic [WORD_BITS-1:0]         ring_word,
  output logic [$clog2(WORD_BITS)-1:0] ring_tag,
  output logic [$clog2(WORD_BITS)-1:0] drain_rank,
  output logic                         drain_lsb,
  output cell_cmp_t                    cmp
);

  localparam int IDX_W = $clog2(WORD_BITS);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [WORD_BITS-1:0] mine;
  logic [IDX_W-1:0]     rank;
  logic                 ahead;

  // Compare the passing rotation with the own one; ties go by rotation order
  assign cmp.lt = ring_word < mine;
  assign cmp.eq = ring_word == mine;
  assign ahead  = cmp.lt || (cmp.eq && (ring_tag < MY_IDX));

  // Load own rotation, then count and pass the ring value to the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mine      <= load_word;
      ring_word <= load_word;
      ring_tag  <= MY_IDX;
      rank      <= '0;
    end else if (ctrl.step) begin
      ring_word <= ring_word_in;
      ring_tag  <= ring_tag_in;
      rank      <= rank + IDX_W'(ahead);
    end
  end

  // Capture the finished rank, then shift it toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      drain_rank <= rank;
      drain_lsb  <= mine[0];
    end else if (ctrl.shift) begin
      drain_rank <= drain_rank_in;
      drain_lsb  <= drain_lsb_in;
    end
  end

endmodule

>>> rtl/bitwise_bwt_encode_64_core.sv
// Top level of the bitwise BWT encoder: a ring of rank cells, a drain chain
// that collects the last column, and an output register.
// Depends on bbwt_pkg, bbwt_if and bbwt_cell.

// One word of WORD_BITS bits is loaded into a ring of WORD_BITS rank cells,
// cell k holding the word rotated right by k. The ring then passes every
// rotation past every cell, one rotation per cell per cycle, and
// each cell counts the rotations that sort ahead of its own (ties kept in
// rotation order). The ranks and last-column bits are then captured into a
// drain chain that moves one cell per cycle into the result register, while
// the ring already ranks the next word. A new word is taken only once the
// ring has ranked the previous one, together with the capture of its ranks;
// a stalled result holds off that capture and thus the input. Bits of
// word_in at and above WORD_BITS are ignored and the matching bits of
// word_out are zero.
module bitwise_bwt_encode_64_core import bbwt_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst,
  bbwt_in_if.sink    words,
  bbwt_out_if.source results
);

  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);

  // Cell interconnect
  cell_ctrl_t           ctrl;
  cell_cmp_t            cmp        [WORD_BITS];
  logic [WORD_BITS-1:0] rot_init   [WORD_BITS];
  logic [WORD_BITS-1:0] ring_word  [WORD_BITS];
  logic [IDX_W-1:0]     ring_tag   [WORD_BITS];
  logic [IDX_W-1:0]     drain_rank [WORD_BITS];
  logic                 drain_lsb  [WORD_BITS];
  logic [WORD_BITS-1:0] word;

  // Ranking stage
  logic             a_busy;
  logic             a_done;
  logic [IDX_W-1:0] a_cnt;
  logic [CNT_W-1:0] le_cnt;

  // Drain stage
  logic                 b_busy;
  logic                 b_done;
  logic [IDX_W-1:0]     b_cnt;
  logic [WORD_BITS-1:0] acc;
  logic [PIDX_W-1:0]    b_pidx;

  logic in_fire;
  logic snap_ok;
  logic b_xfer;

  assign word = words.word_in[WORD_BITS-1:0];

  // Handshake and cell commands
  assign b_xfer      = b_busy && b_done && (!results.valid || results.ready);
  assign snap_ok     = !b_busy || b_xfer;
  assign words.ready = !a_busy || (a_done && snap_ok);
  assign in_fire     = words.valid && words.ready;
  assign ctrl.load   = in_fire;
  assign ctrl.step   = a_busy && !a_done;
  assign ctrl.snap   = a_busy && a_done && snap_ok;
  assign ctrl.shift  = b_busy && !b_done;

  // Build the ring: cell k starts on rotation k, takes from cell k+1
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_cell
    localparam int NXT = (k + 1) % WORD_BITS;

    assign rot_init[k] = (word >> k) | (word << (WORD_BITS - k));

    if (k == WORD_BITS - 1) begin : g_tail
      bbwt_cell #(.WORD_BITS(WORD_BITS), .CELL_IDX(k)) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .load_word    (rot_init[k]),
        .ring_word_in (ring_word[NXT]),
        .ring_tag_in  (ring_tag[NXT]),
        .drain_rank_in('0),
        .drain_lsb_in (1'b0),
        .ring_word    (ring_word[k]),
        .ring_tag     (ring_tag[k]),
        .drain_rank   (drain_rank[k]),
        .drain_lsb    (drain_lsb[k]),
        .cmp          (cmp[k])
      );
    end else begin : g_body
      bbwt_cell #(.WORD_BITS(WORD_BITS), .CELL_IDX(k)) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .load_word    (rot_init[k]),
        .ring_word_in (ring_word[NXT]),
        .ring_tag_in  (ring_tag[NXT]),
        .drain_rank_in(drain_rank[NXT]),
        .drain_lsb_in (drain_lsb[NXT]),
        .ring_word    (ring_word[k]),
        .ring_tag     (ring_tag[k]),
        .drain_rank   (drain_rank[k]),
        .drain_lsb    (drain_lsb[k]),
        .cmp          (cmp[k])
      );
    end
  end

  // Sequence the ranking pass; cell zero holds the input, so count rotations
  // at or below it for the primary index
  always_ff @(posedge clk) begin
    if (rst) begin
      a_busy <= 1'b0;
      a_done <= 1'b0;
    end else if (in_fire) begin
      a_busy <= 1'b1;
      a_done <= 1'b0;
    end else if (ctrl.snap) begin
      a_busy <= 1'b0;
    end else if (ctrl.step && (a_cnt == LAST_IDX)) begin
      a_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_cnt  <= '0;
      le_cnt <= '0;
    end else if (ctrl.step) begin
      a_cnt  <= a_cnt + 1'b1;
      le_cnt <= le_cnt + CNT_W'(cmp[0].lt || cmp[0].eq);
    end
  end

  // Sequence the drain pass
  always_ff @(posedge clk) begin
    if (rst) begin
      b_busy <= 1'b0;
      b_done <= 1'b0;
    end else if (ctrl.snap) begin
      b_busy <= 1'b1;
      b_done <= 1'b0;
    end else if (b_xfer) begin
      b_busy <= 1'b0;
    end else if (ctrl.shift && (b_cnt == LAST_IDX)) begin
      b_done <= 1'b1;
    end
  end

  // Place each drained last-column bit at its sorted position
  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      b_cnt  <= '0;
      acc    <= '0;
      b_pidx <= PIDX_W'(le_cnt - 1'b1);
    end else if (ctrl.shift) begin
      b_cnt <= b_cnt + 1'b1;
      acc   <= acc | (WORD_BITS'(drain_lsb[0]) << (LAST_IDX - drain_rank[0]));
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (b_xfer) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_xfer) begin
      results.word_out      <= DATA_W'(acc);
      results.primary_index <= b_pidx;
    end
  end

endmodule

>>> rtl/bbwt_checker.sv
// Port-level checker for the bitwise BWT encoder and its bind statement.
// Depends on bbwt_pkg and the top level bitwise_bwt_encode_64_core.
module bbwt_checker import bbwt_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] word_out,
  input logic [PIDX_W-1:0] primary_index
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(primary_index))
    else $error("stalled result changed or dropped");

  // Drop input ready while a word is being ranked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while ranking is in progress");

  // Keep bits above the word width clear
  a_out_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_out >> WORD_BITS) == '0)
    else $error("result bits above the word width set");

  // Keep the primary index inside the word
  a_pidx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> primary_index < WORD_BITS)
    else $error("primary index out of range");

  // Show no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bitwise_bwt_encode_64_core bbwt_checker #(.WORD_BITS(WORD_BITS)) u_bbwt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (words.valid),
  .in_ready     (words.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .word_out     (results.word_out),
  .primary_index(results.primary_index)
);

>>> test/bwt_result_checker.sv
// Result checker for the bitwise BWT encoder: watches both channels, predicts
// the transform of every accepted word and compares it with the result stream.
// Depends on bbwt_pkg and the channel interfaces in bbwt_if.
module bwt_result_checker import bbwt_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  bbwt_in_if   words,
  bbwt_out_if  results,
  output int   errors,
  output int   outstanding
);

  // Keep the log readable when the block is badly broken
  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic [DATA_W-1:0] last_column;
    logic [PIDX_W-1:0] primary;
  } bwt_result_t;

  bwt_result_t pending_results [$];
  int          mismatch_count = 0;

  // Rank all right-rotations (stable), gather their low bits in rank order
  // and find the last rank that holds the unrotated word.
  function automatic bwt_result_t transform_word(logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] rot [WORD_BITS];
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] r;
    bwt_result_t       res;
    int                rank;
    int                at_or_below;
    mask = '0;
    for (int i = 0; i < WORD_BITS; i++) mask[i] = 1'b1;
    w = raw & mask;
    r = w;
    for (int k = 0; k < WORD_BITS; k++) begin
      rot[k] = r;
      r = ((r >> 1) | ({{(DATA_W-1){1'b0}}, r[0]} << (WORD_BITS - 1))) & mask;
    end
    res = '0;
    at_or_below = 0;
    for (int k = 0; k < WORD_BITS; k++) begin
      rank = 0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (rot[j] < rot[k] || (rot[j] == rot[k] && j < k)) rank++;
      end
      if (rot[k][0]) res.last_column[WORD_BITS-1-rank] = 1'b1;
      if (rot[k] <= w) at_or_below++;
    end
    res.primary = PIDX_W'(at_or_below - 1);
    return res;
  endfunction

  // Compare each result transaction with the oldest prediction, then queue
  // the prediction for a word accepted on the same edge.
  always @(posedge clk) begin : watch
    bwt_result_t want;
    if (!rst) begin
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("unexpected result: word_out=%h primary_index=%0d",
                   results.word_out, results.primary_index);
        end else begin
          want = pending_results.pop_front();
          if (results.word_out !== want.last_column) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("word_out: expected %h, actual %h",
                     want.last_column, results.word_out);
          end
          if (results.primary_index !== want.primary) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("primary_index: expected %0d, actual %0d",
                     want.primary, results.primary_index);
          end
        end
      end
      if (words.valid && words.ready)
        pending_results.push_back(transform_word(words.word_in));
    end
    errors      <= mismatch_count;
    outstanding <= pending_results.size();
  end

endmodule

>>> test/bitwise_bwt_encode_64_core_tb.sv
// Testbench top for the bitwise BWT encoder: drives corner and random words
// with random idling on both channels and gives the verdict.
// Depends on bbwt_pkg, bbwt_if, the core and bwt_result_checker.
module bitwise_bwt_encode_64_core_tb;
  import bbwt_pkg::*;

  localparam int WORD_BITS    = 64;
  localparam int RANDOM_WORDS = 1100;
  localparam int TAIL_WORDS   = 150;
  localparam int DRAIN_AT     = 400;
  localparam int SETTLE       = 2 * WORD_BITS + 2 + 40;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst;
  bit   quiet_tail;
  int   errors;
  int   outstanding;

  bbwt_in_if  words_ch ();
  bbwt_out_if results_ch ();

  bitwise_bwt_encode_64_core #(.WORD_BITS(WORD_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .words   (words_ch),
    .results (results_ch)
  );

  bwt_result_checker #(.WORD_BITS(WORD_BITS)) scoreboard (
    .clk         (clk),
    .rst         (rst),
    .words       (words_ch),
    .results     (results_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // End the run if the block hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Toggle ready in random stretches; hold it high in the tail
  initial begin : result_sink
    int span;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        results_ch.ready <= 1'b0;
        span = $urandom_range(1, 14);
      end else begin
        results_ch.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Offer one word, after an occasional idle burst; return on acceptance
  task automatic offer_word(input logic [DATA_W-1:0] w);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      words_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    words_ch.valid   <= 1'b1;
    words_ch.word_in <= w;
    do @(posedge clk); while (!words_ch.ready);
  endtask

  // Mix of dense random, periodic, sparse, nearly full and run-shaped words
  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] w;
    logic [31:0]       pattern;
    int                period;
    int                start;
    int                kind;
    kind = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    case (kind)
      4, 5: begin
        period  = 1 << $urandom_range(0, 5);
        pattern = $urandom;
        for (int i = 0; i < DATA_W; i++) w[i] = pattern[i % period];
      end
      6: begin
        w = '0;
        repeat ($urandom_range(1, 4)) w[$urandom_range(0, DATA_W - 1)] = 1'b1;
      end
      7: begin
        w = '1;
        repeat ($urandom_range(1, 4)) w[$urandom_range(0, DATA_W - 1)] = 1'b0;
      end
      8: begin
        start = $urandom_range(0, DATA_W - 1);
        w = '0;
        for (int i = 0; i < $urandom_range(1, DATA_W); i++)
          w[(start + i) % DATA_W] = 1'b1;
      end
      9: w = w >> $urandom_range(0, DATA_W - 1);
      default: ;
    endcase
    return w;
  endfunction

  initial begin : stimulus
    logic [DATA_W-1:0] corner_words [$];
    corner_words = '{
      64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0,
      64'h00FF_00FF_00FF_00FF, 64'h0000_FFFF_0000_FFFF,
      64'h0000_0000_FFFF_FFFF, 64'hDEAD_BEEF_DEAD_BEEF,
      64'h1234_1234_1234_1234, 64'h0123_4567_89AB_CDEF,
      64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_0003,
      64'hC000_0000_0000_0001, 64'h8000_0000_0000_0001,
      64'h6DB6_DB6D_B6DB_6DB6, 64'h1111_1111_1111_1111,
      64'h0000_0001_0000_0001
    };
    rst              <= 1'b1;
    quiet_tail       <= 1'b0;
    words_ch.valid   <= 1'b0;
    words_ch.word_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner words: extremes, periodic words, single set and clear bits
    foreach (corner_words[i]) offer_word(corner_words[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - TAIL_WORDS) quiet_tail <= 1'b1;
      // Hold off until the result queue has fully drained
      if (i == DRAIN_AT) begin
        words_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      offer_word(pick_word());
    end
    words_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
